// ===== rtl/epi_pkg.sv =====
package epi_pkg;
    localparam int ENTITY_SLOTS = 32;
    localparam int SLOT_W = (ENTITY_SLOTS > 1) ? $clog2(ENTITY_SLOTS) : 1;
    localparam int CNT_W = $clog2(ENTITY_SLOTS + 1);
    localparam int TIME_W = 40;
    localparam int POS_W = 32;
    localparam int ID_W = 32;
    localparam int ALPHA_W = 17;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
    localparam logic [TIME_W-1:0] FREEZE_RESET = 40'd1000;
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic [POS_W-1:0] h;
        logic [TIME_W-1:0] t;
    } pose_t;

    localparam int POSE_W = $bits(pose_t);
endpackage

// ===== rtl/epi_ram.sv =====
module epi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/entity_pose_interpolator.sv =====
// Chan | Valid   | Ready   | Payload
// in   | s_valid | s_ready | s_mode s_entity_id s_pos_x/y/z s_heading_in s_pose/render_time
// out  | m_valid | m_ready | m_out_id m_out_x/y/z m_out_heading m_frozen m_frozen_total_out m_last
// Update: reads and checks each slot in turn for the id, then writes the matching slot or the first free one.
// Query: per valid slot, table read, 16-step restoring divide, four lerp multiplies on one shared
// multiplier, then the beat; a clamped alpha skips the divide, no usable previous pose skips both.
// Reset (aresetn low, synchronous) clears valid bits and counters, limit back to 1000.
// A stalled result holds the sequencer; s_ready is high only while idle.
module entity_pose_interpolator
    import epi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [TIME_W-1:0]        cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic [ID_W-1:0]          s_entity_id,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_y,
    input  logic signed [POS_W-1:0]  s_pos_z,
    input  logic signed [POS_W-1:0]  s_heading_in,
    input  logic [TIME_W-1:0]        s_pose_time,
    input  logic [TIME_W-1:0]        s_render_time,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ID_W-1:0]          m_out_id,
    output logic signed [POS_W-1:0]  m_out_x,
    output logic signed [POS_W-1:0]  m_out_y,
    output logic signed [POS_W-1:0]  m_out_z,
    output logic signed [POS_W-1:0]  m_out_heading,
    output logic                     m_frozen,
    output logic [31:0]              m_frozen_total_out,
    output logic                     m_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_UPD_WR,
        S_Q_NEXT, S_Q_RD, S_Q_LOAD, S_Q_DIV, S_Q_MUL, S_Q_EMIT
    } state_t;

    state_t state_reg;
    logic [TIME_W-1:0] limit_reg;
    logic [ENTITY_SLOTS-1:0] valid_reg, hasprev_reg;
    logic [31:0] ftot_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic found_reg, free_ok_reg;
    logic [SLOT_W-1:0] free_reg;
    logic [ID_W-1:0] in_id_reg;
    logic [POS_W-1:0] in_x_reg, in_y_reg, in_z_reg, in_h_reg;
    logic [TIME_W-1:0] in_t_reg;
    pose_t cur_q, prv_q;
    logic [TIME_W:0] rem_reg;
    logic [TIME_W-1:0] span_reg, num_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [4:0] step_reg;
    logic [1:0] comp_reg;
    logic [POS_W-1:0] res_reg [4];
    logic [POS_W:0] diff_reg;
    logic mul_ph_reg;

    logic cur_we, prv_we;
    logic [SLOT_W-1:0] waddr, raddr;
    pose_t cur_wd;

    assign raddr = (state_reg == S_IDLE) ? '0 : idx_reg[SLOT_W-1:0];

    epi_ram #(.WIDTH(POSE_W), .DEPTH(1 << SLOT_W)) u_cur (
        .aclk(aclk), .we(cur_we), .waddr(waddr), .wdata(cur_wd),
        .raddr(raddr), .rdata(cur_q));
    epi_ram #(.WIDTH(POSE_W), .DEPTH(1 << SLOT_W)) u_prv (
        .aclk(aclk), .we(prv_we), .waddr(waddr), .wdata(cur_q),
        .raddr(raddr), .rdata(prv_q));

    assign waddr = slot_reg;
    assign cur_wd = '{id: in_id_reg, x: in_x_reg, y: in_y_reg, z: in_z_reg,
                      h: in_h_reg, t: in_t_reg};
    assign cur_we = (state_reg == S_UPD_WR) && (found_reg || free_ok_reg);
    assign prv_we = (state_reg == S_UPD_WR) && found_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_Q_EMIT);
    assign m_out_x = res_reg[0];
    assign m_out_y = res_reg[1];
    assign m_out_z = res_reg[2];
    assign m_out_heading = res_reg[3];
    assign m_frozen_total_out = ftot_reg;

    logic [TIME_W:0] sub_w;
    logic [TIME_W:0] frz_sum;
    logic signed [POS_W+ALPHA_W+1:0] mul_w;
    logic [POS_W-1:0] prv_c, cur_c;
    logic [CNT_W-1:0] nxt;
    logic more;

    assign sub_w = {rem_reg[TIME_W-1:0], 1'b0} - {1'b0, span_reg};
    assign frz_sum = {1'b0, cur_q.t} + {1'b0, limit_reg};
    assign mul_w = $signed(diff_reg) * $signed({1'b0, alpha_reg});

    always_comb begin
        case (comp_reg)
            2'd0: begin prv_c = prv_q.x; cur_c = cur_q.x; end
            2'd1: begin prv_c = prv_q.y; cur_c = cur_q.y; end
            2'd2: begin prv_c = prv_q.z; cur_c = cur_q.z; end
            default: begin prv_c = prv_q.h; cur_c = cur_q.h; end
        endcase
    end

    always_comb begin
        nxt = idx_reg;
        more = 1'b0;
        for (int i = ENTITY_SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[i] && (CNT_W'(i) >= idx_reg)) begin
                nxt = CNT_W'(i);
                more = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            limit_reg <= FREEZE_RESET;
            valid_reg <= '0;
            hasprev_reg <= '0;
            ftot_reg <= '0;
            idx_reg <= '0;
            m_last <= 1'b0;
            m_frozen <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_id_reg <= s_entity_id;
                        in_x_reg <= s_pos_x;
                        in_y_reg <= s_pos_y;
                        in_z_reg <= s_pos_z;
                        in_h_reg <= s_heading_in;
                        in_t_reg <= s_pose_time;
                        num_reg <= s_render_time;
                        idx_reg <= '0;
                        found_reg <= 1'b0;
                        free_ok_reg <= 1'b0;
                        state_reg <= (s_mode == MODE_QUERY) ? S_Q_NEXT : S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    if (idx_reg == CNT_W'(ENTITY_SLOTS)) begin
                        slot_reg <= free_reg;
                        state_reg <= S_UPD_WR;
                    end else begin
                        state_reg <= S_SRCH_CHK;
                    end
                end
                S_SRCH_CHK: begin
                    if (valid_reg[idx_reg[SLOT_W-1:0]] && cur_q.id == in_id_reg) begin
                        found_reg <= 1'b1;
                        slot_reg <= idx_reg[SLOT_W-1:0];
                        state_reg <= S_UPD_WR;
                    end else begin
                        if (!valid_reg[idx_reg[SLOT_W-1:0]] && !free_ok_reg) begin
                            free_ok_reg <= 1'b1;
                            free_reg <= idx_reg[SLOT_W-1:0];
                        end
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_UPD_WR: begin
                    if (found_reg) begin
                        hasprev_reg[slot_reg] <= 1'b1;
                    end else if (free_ok_reg) begin
                        valid_reg[slot_reg] <= 1'b1;
                        hasprev_reg[slot_reg] <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
                S_Q_NEXT: begin
                    if (more) begin
                        idx_reg <= nxt;
                        state_reg <= S_Q_RD;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_Q_RD: begin
                    state_reg <= S_Q_LOAD;
                end
                S_Q_LOAD: begin
                    m_out_id <= cur_q.id;
                    m_frozen <= frz_sum < {1'b0, num_reg};
                    span_reg <= cur_q.t - prv_q.t;
                    rem_reg <= {1'b0, num_reg - prv_q.t};
                    step_reg <= '0;
                    comp_reg <= '0;
                    mul_ph_reg <= 1'b0;
                    if (!(hasprev_reg[idx_reg[SLOT_W-1:0]] && (cur_q.t > prv_q.t))) begin
                        res_reg[0] <= cur_q.x;
                        res_reg[1] <= cur_q.y;
                        res_reg[2] <= cur_q.z;
                        res_reg[3] <= cur_q.h;
                        state_reg <= S_Q_EMIT;
                    end else if (num_reg <= prv_q.t) begin
                        alpha_reg <= '0;
                        state_reg <= S_Q_MUL;
                    end else if (num_reg - prv_q.t >= cur_q.t - prv_q.t) begin
                        alpha_reg <= ALPHA_ONE;
                        state_reg <= S_Q_MUL;
                    end else begin
                        alpha_reg <= '0;
                        state_reg <= S_Q_DIV;
                    end
                    if (frz_sum < {1'b0, num_reg} && ftot_reg != 32'hFFFF_FFFF) begin
                        ftot_reg <= ftot_reg + 1'b1;
                    end
                end
                S_Q_DIV: begin
                    // remainder < span, so shifted remainder fits in TIME_W+1 bits
                    if (!sub_w[TIME_W]) begin
                        rem_reg <= {1'b0, sub_w[TIME_W-1:0]};
                        alpha_reg <= {alpha_reg[ALPHA_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[TIME_W-1:0], 1'b0};
                        alpha_reg <= {alpha_reg[ALPHA_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd15) begin
                        state_reg <= S_Q_MUL;
                    end
                end
                S_Q_MUL: begin
                    if (!mul_ph_reg) begin
                        diff_reg <= {cur_c[POS_W-1], cur_c} - {prv_c[POS_W-1], prv_c};
                        mul_ph_reg <= 1'b1;
                    end else begin
                        res_reg[comp_reg] <= prv_c + mul_w[POS_W+15:16];
                        mul_ph_reg <= 1'b0;
                        comp_reg <= comp_reg + 1'b1;
                        if (comp_reg == 2'd3) begin
                            state_reg <= S_Q_EMIT;
                        end
                    end
                end
                S_Q_EMIT: begin
                    if (m_ready) begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_Q_NEXT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_Q_LOAD) begin
                m_last <= 1'b1;
                for (int i = 0; i < ENTITY_SLOTS; i++) begin
                    if (valid_reg[i] && (CNT_W'(i) > idx_reg)) begin
                        m_last <= 1'b0;
                    end
                end
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_last))
        else $error("result beat changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input taken while a result is pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ftot_reg == 32'hFFFF_FFFF |=> ftot_reg == 32'hFFFF_FFFF)
        else $error("frozen total wrapped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD_WR) |=> $countones(valid_reg) >= $countones($past(valid_reg)))
        else $error("update lost a slot");
endmodule

// ===== tb/tb_entity_pose_interpolator.sv =====
module tb_entity_pose_interpolator;
    import epi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic              mode;
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  z;
        logic [POS_W-1:0]  h;
        logic [TIME_W-1:0] pose_t;
        logic [TIME_W-1:0] render_t;
    } pose_beat_t;

    typedef struct {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic [POS_W-1:0] h;
        logic             frozen;
        logic [31:0]      frozen_total;
        logic             last;
    } view_beat_t;

    class pose_scoreboard;
        logic              used[ENTITY_SLOTS];
        logic [ID_W-1:0]   ids[ENTITY_SLOTS];
        logic              prior_ok[ENTITY_SLOTS];
        longint            px[ENTITY_SLOTS], py[ENTITY_SLOTS];
        longint            pz[ENTITY_SLOTS], ph[ENTITY_SLOTS];
        longint            cx[ENTITY_SLOTS], cy[ENTITY_SLOTS];
        longint            cz[ENTITY_SLOTS], ch[ENTITY_SLOTS];
        logic [TIME_W-1:0] pt[ENTITY_SLOTS], ct[ENTITY_SLOTS];
        logic [TIME_W-1:0] freeze_limit;
        logic [31:0]       frozen_count;
        view_beat_t        pending_views[$];
        int                errors;
        int                updates, queries, views_checked, frozen_seen;

        function new();
            freeze_limit = FREEZE_RESET;
            frozen_count = 0;
            errors = 0;
            updates = 0;
            queries = 0;
            views_checked = 0;
            frozen_seen = 0;
            for (int i = 0; i < ENTITY_SLOTS; i++) begin
                used[i] = 0;
                prior_ok[i] = 0;
            end
        endfunction

        function longint blend(longint a, longint b, longint alpha);
            longint prod;
            prod = (b - a) * alpha;
            return a + (prod >>> 16);
        endfunction

        function void note_beat(pose_beat_t b);
            int slot;
            int n;
            longint span, alpha;
            view_beat_t v;
            logic [TIME_W:0] lim_sum;
            slot = -1;
            if (b.mode == MODE_UPDATE) begin
                updates++;
                for (int i = 0; i < ENTITY_SLOTS; i++)
                    if (slot < 0 && used[i] && ids[i] == b.id) slot = i;
                if (slot >= 0) begin
                    px[slot] = cx[slot];
                    py[slot] = cy[slot];
                    pz[slot] = cz[slot];
                    ph[slot] = ch[slot];
                    pt[slot] = ct[slot];
                    prior_ok[slot] = 1;
                end else begin
                    for (int i = 0; i < ENTITY_SLOTS; i++)
                        if (slot < 0 && !used[i]) slot = i;
                    if (slot < 0) return;
                    used[slot] = 1;
                    ids[slot] = b.id;
                    prior_ok[slot] = 0;
                end
                cx[slot] = longint'(signed'(b.x));
                cy[slot] = longint'(signed'(b.y));
                cz[slot] = longint'(signed'(b.z));
                ch[slot] = longint'(signed'(b.h));
                ct[slot] = b.pose_t;
                return;
            end
            queries++;
            n = 0;
            for (int i = 0; i < ENTITY_SLOTS; i++) begin
                if (!used[i]) continue;
                v.id = ids[i];
                if (prior_ok[i] && ct[i] > pt[i]) begin
                    span = longint'(ct[i] - pt[i]);
                    if (b.render_t <= pt[i])
                        alpha = 0;
                    else if (longint'(b.render_t - pt[i]) >= span)
                        alpha = 65536;
                    else
                        alpha = (longint'(b.render_t - pt[i]) << 16) / span;
                    v.x = POS_W'(blend(px[i], cx[i], alpha));
                    v.y = POS_W'(blend(py[i], cy[i], alpha));
                    v.z = POS_W'(blend(pz[i], cz[i], alpha));
                    v.h = POS_W'(blend(ph[i], ch[i], alpha));
                end else begin
                    v.x = POS_W'(cx[i]);
                    v.y = POS_W'(cy[i]);
                    v.z = POS_W'(cz[i]);
                    v.h = POS_W'(ch[i]);
                end
                lim_sum = {1'b0, ct[i]} + {1'b0, freeze_limit};
                v.frozen = lim_sum < {1'b0, b.render_t};
                if (v.frozen && frozen_count != 32'hFFFF_FFFF) frozen_count++;
                v.frozen_total = frozen_count;
                v.last = 0;
                pending_views = {pending_views, v};
                n++;
            end
            if (n > 0) pending_views[$].last = 1;
        endfunction

        function void cmp(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_view(view_beat_t got);
            view_beat_t want;
            if (pending_views.size() == 0) begin
                $error("result beat for id %0h with nothing expected", got.id);
                errors++;
                return;
            end
            want = pending_views.pop_front();
            views_checked++;
            if (got.frozen === 1'b1) frozen_seen++;
            cmp("out_id", want.id, got.id);
            cmp("out_x", want.x, got.x);
            cmp("out_y", want.y, got.y);
            cmp("out_z", want.z, got.z);
            cmp("out_heading", want.h, got.h);
            cmp("frozen", want.frozen, got.frozen);
            cmp("frozen_total_out", want.frozen_total, got.frozen_total);
            cmp("last", want.last, got.last);
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [TIME_W-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic s_mode = 0;
    logic [ID_W-1:0] s_entity_id = '0;
    logic signed [POS_W-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0, s_heading_in = '0;
    logic [TIME_W-1:0] s_pose_time = '0, s_render_time = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [ID_W-1:0] m_out_id;
    logic signed [POS_W-1:0] m_out_x, m_out_y, m_out_z, m_out_heading;
    logic m_frozen;
    logic [31:0] m_frozen_total_out;
    logic m_last;

    entity_pose_interpolator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_entity_id(s_entity_id), .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .s_pos_z(s_pos_z), .s_heading_in(s_heading_in),
        .s_pose_time(s_pose_time), .s_render_time(s_render_time),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_id(m_out_id),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .m_out_heading(m_out_heading), .m_frozen(m_frozen),
        .m_frozen_total_out(m_frozen_total_out), .m_last(m_last)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    pose_scoreboard sb = new();
    int cycle_count = 0;
    int ready_pct = 100;
    logic [ID_W-1:0] id_pool[40];
    logic [TIME_W-1:0] t_now = 40'd5000;
    int burst_left = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("entity_pose_interpolator: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        view_beat_t got;
        if (cycle_count % 300 == 0) ready_pct <= ($urandom_range(0, 2) == 0) ? 100 :
                                                 $urandom_range(20, 90);
        m_ready <= ($urandom_range(1, 100) <= ready_pct);
        if (aresetn && m_valid && m_ready) begin
            got.id = m_out_id;
            got.x = m_out_x;
            got.y = m_out_y;
            got.z = m_out_z;
            got.h = m_out_heading;
            got.frozen = m_frozen;
            got.frozen_total = m_frozen_total_out;
            got.last = m_last;
            sb.check_view(got);
        end
    end

    function automatic logic [TIME_W-1:0] rand40();
        return TIME_W'({$urandom, $urandom});
    endfunction

    task automatic send_beat(pose_beat_t b);
        if (burst_left == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) :
                         $urandom_range(1, 5);
        end
        burst_left--;
        s_valid <= 1;
        s_mode <= b.mode;
        s_entity_id <= b.id;
        s_pos_x <= b.x;
        s_pos_y <= b.y;
        s_pos_z <= b.z;
        s_heading_in <= b.h;
        s_pose_time <= b.pose_t;
        s_render_time <= b.render_t;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(b);
    endtask

    task automatic write_limit(logic [TIME_W-1:0] val);
        s_valid <= 0;
        burst_left = 0;
        while (sb.pending_views.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        sb.freeze_limit = val;
    endtask

    function automatic pose_beat_t upd(logic [ID_W-1:0] id, logic [POS_W-1:0] p,
                                       logic [TIME_W-1:0] t);
        pose_beat_t b;
        b.mode = MODE_UPDATE;
        b.id = id;
        b.x = p;
        b.y = ~p;
        b.z = p ^ 32'h5A5A_5A5A;
        b.h = p + 32'd12345;
        b.pose_t = t;
        b.render_t = rand40();
        return b;
    endfunction

    function automatic pose_beat_t qry(logic [TIME_W-1:0] r);
        pose_beat_t b;
        b.mode = MODE_QUERY;
        b.id = $urandom;
        b.x = $urandom;
        b.y = $urandom;
        b.z = $urandom;
        b.h = $urandom;
        b.pose_t = rand40();
        b.render_t = r;
        return b;
    endfunction

    function automatic pose_beat_t random_beat();
        pose_beat_t b;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 9))
                0: b = qry(rand40());
                1: b = qry('0);
                default: b = qry(t_now - 40'd1500 + TIME_W'($urandom_range(0, 4000)));
            endcase
            return b;
        end
        t_now += TIME_W'($urandom_range(0, 300));
        b = upd(($urandom_range(0, 6) == 0) ? $urandom : id_pool[$urandom_range(0, 39)],
                $urandom, t_now);
        b.y = $urandom;
        b.z = $urandom;
        b.h = $urandom;
        case ($urandom_range(0, 11))
            0: b.pose_t = rand40();
            1: b.pose_t = t_now - TIME_W'($urandom_range(0, 1500));
            default: ;
        endcase
        return b;
    endfunction

    initial begin
        foreach (id_pool[i]) id_pool[i] = $urandom;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        write_limit(FREEZE_RESET);
        send_beat(qry(rand40()));
        send_beat(upd('0, 32'h7FFF_FFFF, 40'd100));
        send_beat(upd(32'hFFFF_FFFF, 32'h8000_0000, 40'd0));
        send_beat(qry(40'd50));
        send_beat(upd('0, 32'h8000_0000, 40'd1100));
        send_beat(upd(32'hFFFF_FFFF, 32'h7FFF_FFFF, 40'd0));
        send_beat(qry(40'd50));
        send_beat(qry(40'd600));
        send_beat(qry(40'd1100));
        send_beat(qry(40'd5000));
        send_beat(upd('0, 32'h0001_0000, 40'd500));
        send_beat(qry(40'hFF_FFFF_FFFF));
        send_beat(upd(32'h1234_5678, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF));
        send_beat(upd(32'h1234_5678, 32'h0000_0000, 40'hFF_FFFF_FFFF));
        send_beat(qry(40'hFF_FFFF_FFFF));
        send_beat(qry('0));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_limit('0);
                1: write_limit(40'hFF_FFFF_FFFF);
                2: write_limit(TIME_W'($urandom_range(0, 3000)));
                default: write_limit(FREEZE_RESET);
            endcase
            repeat (115) send_beat(random_beat());
        end

        s_valid <= 0;
        while (sb.pending_views.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d pose updates and %0d render queries, %0d result beats checked",
                 sb.updates, sb.queries, sb.views_checked);
        $display("%0d frozen beats seen, final frozen total %0d",
                 sb.frozen_seen, sb.frozen_count);
        if (sb.errors == 0 && sb.pending_views.size() == 0)
            $display("entity_pose_interpolator: match");
        else
            $display("entity_pose_interpolator: mismatch");
        $finish;
    end
endmodule

// ===== entity_pose_interpolator.f =====
rtl/epi_pkg.sv
rtl/epi_ram.sv
rtl/entity_pose_interpolator.sv
tb/tb_entity_pose_interpolator.sv
